[rtl/core/utf8_case_map_and_char_boundaries_top_assert.svh]
// assertion macros used by the top-level rtl file
`ifndef UTF8_CASE_MAP_AND_CHAR_BOUNDARIES_TOP_ASSERT_SVH
`define UTF8_CASE_MAP_AND_CHAR_BOUNDARIES_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define U8CB_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// concurrent check on the block clock and reset
`define U8CB_ASSERT(lbl, prop, msg) \
  `U8CB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define U8CB_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define U8CB_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/core/u8cb_pkg.sv]
package u8cb_pkg;

  // width of the per-text byte counter
  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned OUT_OFFSET_W = 32;

  localparam logic [OFFSET_WIDTH-1:0] POS_ZERO = '0;
  localparam logic [OFFSET_WIDTH-1:0] POS_ONE  = {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};

  // case mapping modes
  typedef enum logic [1:0] {
    CASE_NONE  = 2'd0,
    CASE_LOWER = 2'd1,
    CASE_UPPER = 2'd2,
    CASE_TITLE = 2'd3
  } fold_mode_e;

  localparam fold_mode_e FOLD_MODE_RESET = CASE_LOWER;

  // utf-8 lead and continuation patterns
  localparam logic [7:0] LEAD1_MASK  = 8'h80;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] CONT_CODE   = 8'h80;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] LEAD4_CODE  = 8'hF0;

  // ascii letter and whitespace codes
  localparam logic [7:0] UC_A       = 8'h41;
  localparam logic [7:0] UC_Z       = 8'h5A;
  localparam logic [7:0] LC_A       = 8'h61;
  localparam logic [7:0] LC_Z       = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] WS_LO      = 8'h09;
  localparam logic [7:0] WS_HI      = 8'h0D;

  // per-text tracking state
  typedef struct packed {
    logic [1:0]              pend;
    logic                    err;
    logic                    cap;
    logic [OFFSET_WIDTH-1:0] pos;
  } trk_state_t;

  localparam trk_state_t TRK_RESET = '{pend: 2'd0, err: 1'b0, cap: 1'b1, pos: POS_ZERO};

  // one result item
  typedef struct packed {
    logic [7:0]              text_byte;
    logic                    char_start;
    logic [2:0]              char_length;
    logic [OUT_OFFSET_W-1:0] char_offset;
    logic                    end_of_text;
    logic                    text_valid;
  } result_t;

endpackage

[rtl/core/u8cb_in_if.sv]
interface u8cb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/core/u8cb_out_if.sv]
interface u8cb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        char_start;
  logic [2:0]  char_length;
  logic [31:0] char_offset;
  logic        end_of_text;
  logic        text_valid;

  modport source (output valid, output text_byte, output char_start, output char_length,
                  output char_offset, output end_of_text, output text_valid, input ready);
  modport sink (input valid, input text_byte, input char_start, input char_length,
                input char_offset, input end_of_text, input text_valid, output ready);
endinterface

[rtl/core/u8cb_cfg_if.sv]
interface u8cb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] fold_mode;

  modport source (output valid, output fold_mode, input ready);
  modport sink (input valid, input fold_mode, output ready);
endinterface

[rtl/core/u8cb_byte_eval.sv]
module u8cb_byte_eval (
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic [1:0]           fold_mode_i,
  input  u8cb_pkg::trk_state_t state_i,
  output u8cb_pkg::trk_state_t state_o,
  output u8cb_pkg::result_t    result_o
);
  import u8cb_pkg::*;

  logic       is_upper;
  logic       is_lower;
  logic       is_space;
  logic [7:0] lower_byte;
  logic [7:0] upper_byte;
  logic [7:0] mapped;
  logic       start;
  logic [2:0] len;
  logic       err_n;
  logic [1:0] pend_n;

  // ascii classification
  assign is_upper   = (data_byte_i >= UC_A) && (data_byte_i <= UC_Z);
  assign is_lower   = (data_byte_i >= LC_A) && (data_byte_i <= LC_Z);
  assign is_space   = (data_byte_i == SPACE_CODE) ||
                      ((data_byte_i >= WS_LO) && (data_byte_i <= WS_HI));
  assign lower_byte = is_upper ? (data_byte_i + CASE_DELTA) : data_byte_i;
  assign upper_byte = is_lower ? (data_byte_i - CASE_DELTA) : data_byte_i;

  // case mapping
  always_comb begin
    case (fold_mode_i)
      CASE_NONE:  mapped = data_byte_i;
      CASE_LOWER: mapped = lower_byte;
      CASE_UPPER: mapped = upper_byte;
      CASE_TITLE: mapped = state_i.cap ? upper_byte : lower_byte;
      default:    mapped = data_byte_i;
    endcase
  end

  // utf-8 lead and continuation check
  always_comb begin
    start  = 1'b0;
    len    = 3'd0;
    err_n  = state_i.err;
    pend_n = 2'd0;
    if (state_i.pend != 2'd0) begin
      if ((data_byte_i & CONT_MASK) != CONT_CODE) begin
        err_n = 1'b1;
      end
      pend_n = state_i.pend - 2'd1;
    end else begin
      start = 1'b1;
      if ((data_byte_i & LEAD1_MASK) == 8'h00) begin
        len = 3'd1;
      end else if ((data_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
        len = 3'd2;
        if (data_byte_i < LEAD2_MIN) begin
          err_n = 1'b1;
        end
      end else if ((data_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
        len = 3'd3;
      end else if ((data_byte_i & LEAD4_MASK) == LEAD4_CODE) begin
        len = 3'd4;
        if (data_byte_i > LEAD4_MAX) begin
          err_n = 1'b1;
        end
      end else begin
        // stray continuation or invalid lead
        len   = 3'd1;
        err_n = 1'b1;
      end
      pend_n = 2'(len - 3'd1);
    end
    // truncated character at end of text
    if (last_byte_i && (pend_n != 2'd0)) begin
      err_n = 1'b1;
    end
  end

  // result fields
  assign result_o.text_byte   = mapped;
  assign result_o.char_start  = start;
  assign result_o.char_length = len;
  assign result_o.char_offset = OUT_OFFSET_W'(state_i.pos);
  assign result_o.end_of_text = last_byte_i;
  assign result_o.text_valid  = last_byte_i & ~err_n;

  // next state, restart after the final byte
  always_comb begin
    if (last_byte_i) begin
      state_o = TRK_RESET;
    end else begin
      state_o.pend = pend_n;
      state_o.err  = err_n;
      state_o.cap  = is_space;
      state_o.pos  = state_i.pos + POS_ONE;
    end
  end

endmodule

[rtl/core/utf8_case_map_and_char_boundaries_top.sv]
// path: a byte passes through the input register and then the result register to the output
// throughput: one byte per cycle; ready falls only when the result register is stalled
// reset: rst_ni asynchronous active low, clears both stages, tracking state and mode (lower)
// the result register and input register hold payload without reset
module utf8_case_map_and_char_boundaries_top (
  input logic         clk_i,
  input logic         rst_ni,
  u8cb_in_if.sink     in_i,
  u8cb_cfg_if.sink    cfg_i,
  u8cb_out_if.source  out_o
);
  import u8cb_pkg::*;

`include "utf8_case_map_and_char_boundaries_top_assert.svh"

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s2_valid_q;
  result_t    s2_res_q;
  logic [1:0] fold_mode_q;
  trk_state_t trk_q;
  trk_state_t trk_d;
  result_t    res_d;
  logic       s2_adv;
  logic       s1_adv;

  // stage advance control
  assign s2_adv     = !s2_valid_q || out_o.ready;
  assign s1_adv     = s2_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;

  // configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_mode_q <= FOLD_MODE_RESET;
    end else if (cfg_i.valid) begin
      fold_mode_q <= cfg_i.fold_mode;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  // per-byte evaluation
  u8cb_byte_eval u_eval (
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .fold_mode_i (fold_mode_q),
    .state_i     (trk_q),
    .state_o     (trk_d),
    .result_o    (res_d)
  );

  // tracking state, updated as a byte moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= TRK_RESET;
    end else if (s1_valid_q && s1_adv) begin
      trk_q <= trk_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      s2_res_q <= res_d;
    end
  end

  // output channel
  assign out_o.valid       = s2_valid_q;
  assign out_o.text_byte   = s2_res_q.text_byte;
  assign out_o.char_start  = s2_res_q.char_start;
  assign out_o.char_length = s2_res_q.char_length;
  assign out_o.char_offset = s2_res_q.char_offset;
  assign out_o.end_of_text = s2_res_q.end_of_text;
  assign out_o.text_valid  = s2_res_q.text_valid;

  // checks
  `U8CB_ASSERT(a_pos_restart, (s1_valid_q && s1_adv && s1_last_q) |=> (trk_q.pos == POS_ZERO), "position not cleared after final byte")
  `U8CB_ASSERT(a_start_len, out_o.valid |-> (out_o.char_start == (out_o.char_length != 3'd0)), "char_start and char_length disagree")
  `U8CB_ASSERT(a_valid_on_end, out_o.valid && out_o.text_valid |-> out_o.end_of_text, "text_valid without end_of_text")
  `U8CB_ASSERT(a_s1_hold, (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(trk_q)), "input stage lost a stalled byte")

endmodule
